// ===== hdl/rso_pkg.sv =====
// Shared types, constants and helper functions for the speedometer and odometer core.
`timescale 1ns / 1ps

package rso_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int RPM_W   = 16;
  localparam int GEAR_W  = 2;
  localparam int SPEED_W = 12;
  localparam int ODO_W   = 24;

  // Configuration port
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_SIG_FIRST  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SIG_SECOND = 1'b1;

  // Item kinds
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Gears and the raw codes that select them
  localparam logic [GEAR_W-1:0] GEAR_NONE = 2'd0;
  localparam logic [GEAR_W-1:0] GEAR_1    = 2'd1;
  localparam logic [GEAR_W-1:0] GEAR_2    = 2'd2;
  localparam logic [GEAR_W-1:0] GEAR_3    = 2'd3;

  localparam logic [BYTE_W-1:0] GEAR1_CODE_A = 8'd1;
  localparam logic [BYTE_W-1:0] GEAR1_CODE_B = 8'd9;
  localparam logic [BYTE_W-1:0] GEAR1_CODE_C = 8'd65;
  localparam logic [BYTE_W-1:0] GEAR2_CODE_A = 8'd2;
  localparam logic [BYTE_W-1:0] GEAR2_CODE_B = 8'd10;
  localparam logic [BYTE_W-1:0] GEAR2_CODE_C = 8'd66;
  localparam logic [BYTE_W-1:0] GEAR3_CODE_A = 8'd3;
  localparam logic [BYTE_W-1:0] GEAR3_CODE_B = 8'd11;
  localparam logic [BYTE_W-1:0] GEAR3_CODE_C = 8'd67;

  // Per-gear limits
  localparam logic [SPEED_W-1:0] CAPPED_LIMIT_1  = 12'd34;
  localparam logic [SPEED_W-1:0] CAPPED_LIMIT_2  = 12'd53;
  localparam logic [SPEED_W-1:0] CAPPED_LIMIT_3  = 12'd66;
  localparam logic [SPEED_W-1:0] DISPLAY_LIMIT_1 = 12'd40;
  localparam logic [SPEED_W-1:0] DISPLAY_LIMIT_2 = 12'd55;
  localparam logic [SPEED_W-1:0] DISPLAY_LIMIT_3 = 12'd70;

  // base = floor(rpm * 377 / 6250) as (rpm * BASE_MUL) >> BASE_SHIFT, exact for 16-bit rpm
  localparam longint unsigned BASE_NUM   = 377;
  localparam longint unsigned BASE_DEN   = 6250;
  localparam int              BASE_SHIFT = RPM_W + $clog2(BASE_DEN);
  localparam longint unsigned BASE_MUL   =
    ((BASE_NUM << BASE_SHIFT) + BASE_DEN - 1) / BASE_DEN;
  localparam int BASE_MUL_W  = $clog2(BASE_MUL + 1);
  localparam int BASE_PROD_W = RPM_W + BASE_MUL_W;

  // scaled = floor(base * 113 / 100) as (base * DISP_MUL) >> DISP_SHIFT, exact for 12-bit base
  localparam longint unsigned DISP_NUM   = 113;
  localparam longint unsigned DISP_DEN   = 100;
  localparam int              DISP_SHIFT = SPEED_W + $clog2(DISP_DEN);
  localparam longint unsigned DISP_MUL   =
    ((DISP_NUM << DISP_SHIFT) + DISP_DEN - 1) / DISP_DEN;
  localparam int DISP_MUL_W  = $clog2(DISP_MUL + 1);
  localparam int DISP_PROD_W = SPEED_W + DISP_MUL_W;
  localparam int DISP_W      = SPEED_W + 1;

  // Averaging ring and distance
  localparam int AVG_DEPTH    = 5;
  localparam int RING_PTR_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SPEED_MAX    = (1 << SPEED_W) - 1;
  localparam int SUM_MAX      = AVG_DEPTH * SPEED_MAX;
  localparam int SUM_W        = $clog2(SUM_MAX + 1);
  localparam int INC_FACTOR   = 11;
  localparam int INC_MAX      = SUM_MAX * INC_FACTOR;
  localparam int INC_W        = $clog2(INC_MAX + 1);
  localparam int ODO_UNIT     = AVG_DEPTH * 3600;
  localparam int REM_W        = $clog2(ODO_UNIT);
  localparam int ACC_W        = $clog2(ODO_UNIT + INC_MAX);
  localparam int ODO_STEP_MAX = (ODO_UNIT - 1 + INC_MAX) / ODO_UNIT;
  localparam int ODO_STEP_W   = $clog2(ODO_STEP_MAX + 1);
  localparam logic [ODO_W-1:0] ODO_MAX = '1;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] sig_byte_first;
    logic [BYTE_W-1:0] sig_byte_second;
    logic [RPM_W-1:0]  motor_rpm;
    logic [BYTE_W-1:0] gear_code;
  } in_item_t;

  typedef struct packed {
    logic               frame_valid;
    logic [GEAR_W-1:0]  gear_number;
    logic [SPEED_W-1:0] display_speed;
    logic [SPEED_W-1:0] capped_speed;
    logic [ODO_W-1:0]   odo_tenths;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sig_first;
    logic [BYTE_W-1:0] sig_second;
  } cfg_t;

  // Frame fields after the speed scaling stages
  typedef struct packed {
    logic               cmd;
    logic [BYTE_W-1:0]  sig_byte_first;
    logic [BYTE_W-1:0]  sig_byte_second;
    logic [BYTE_W-1:0]  gear_code;
    logic [SPEED_W-1:0] base;
    logic [DISP_W-1:0]  disp_scaled;
  } calc_t;

  typedef struct packed {
    logic               frame_valid;
    logic [GEAR_W-1:0]  gear_number;
    logic [SPEED_W-1:0] display_speed;
    logic [SPEED_W-1:0] capped_speed;
  } status_t;

  typedef struct packed {
    status_t          status;
    logic             fire;
    logic [SUM_W-1:0] ring_sum;
  } state_t;

  function automatic logic [GEAR_W-1:0] decode_gear(input logic [BYTE_W-1:0] code,
                                                    input logic [GEAR_W-1:0] old);
    logic [GEAR_W-1:0] g;
    g = old;
    if (code inside {GEAR1_CODE_A, GEAR1_CODE_B, GEAR1_CODE_C}) begin
      g = GEAR_1;
    end else if (code inside {GEAR2_CODE_A, GEAR2_CODE_B, GEAR2_CODE_C}) begin
      g = GEAR_2;
    end else if (code inside {GEAR3_CODE_A, GEAR3_CODE_B, GEAR3_CODE_C}) begin
      g = GEAR_3;
    end
    return g;
  endfunction

  function automatic logic [SPEED_W-1:0] capped_limit(input logic [GEAR_W-1:0] gear);
    logic [SPEED_W-1:0] lim;
    case (gear)
      GEAR_1:  lim = CAPPED_LIMIT_1;
      GEAR_2:  lim = CAPPED_LIMIT_2;
      GEAR_3:  lim = CAPPED_LIMIT_3;
      default: lim = '0;
    endcase
    return lim;
  endfunction

  function automatic logic [SPEED_W-1:0] display_limit(input logic [GEAR_W-1:0] gear);
    logic [SPEED_W-1:0] lim;
    case (gear)
      GEAR_1:  lim = DISPLAY_LIMIT_1;
      GEAR_2:  lim = DISPLAY_LIMIT_2;
      GEAR_3:  lim = DISPLAY_LIMIT_3;
      default: lim = '0;
    endcase
    return lim;
  endfunction

endpackage

// ===== hdl/rso_cfg_regs.sv =====
// APB-style register file holding the two expected signature bytes.
`timescale 1ns / 1ps

module rso_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rso_pkg::ADDR_W-1:0]   paddr,
  input  logic [rso_pkg::DATA_W-1:0]   pwdata,
  output logic [rso_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output rso_pkg::cfg_t                cfg
);

  logic [rso_pkg::BYTE_W-1:0]    sig_first;
  logic [rso_pkg::BYTE_W-1:0]    sig_second;
  logic [rso_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[rso_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_first  <= '0;
      sig_second <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        rso_pkg::REG_SIG_FIRST:  sig_first  <= pwdata[rso_pkg::BYTE_W-1:0];
        rso_pkg::REG_SIG_SECOND: sig_second <= pwdata[rso_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rso_pkg::REG_SIG_FIRST:  prdata = rso_pkg::DATA_W'(sig_first);
      rso_pkg::REG_SIG_SECOND: prdata = rso_pkg::DATA_W'(sig_second);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.sig_first  = sig_first;
  assign cfg.sig_second = sig_second;

endmodule

// ===== hdl/rso_speed_calc.sv =====
// Input register and the two constant-multiply stages that scale rpm to speed.
`timescale 1ns / 1ps

module rso_speed_calc (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  rso_pkg::in_item_t item,
  output logic              calc_valid,
  input  logic              calc_ready,
  output rso_pkg::calc_t    calc
);

  logic              s1_valid;
  rso_pkg::in_item_t s1_item;
  logic              s2_valid;
  rso_pkg::calc_t    s2_item;
  logic              s3_valid;
  rso_pkg::calc_t    s3_item;
  rso_pkg::calc_t    s3_item_next;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  logic [rso_pkg::BASE_PROD_W-1:0] base_prod;
  logic [rso_pkg::DISP_PROD_W-1:0] disp_prod;

  // A stage takes a new beat when empty or when its beat moves on
  assign s3_ready   = !s3_valid || calc_ready;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign item_ready = s1_ready;

  assign base_prod = rso_pkg::BASE_PROD_W'(s1_item.motor_rpm) *
                     rso_pkg::BASE_PROD_W'(rso_pkg::BASE_MUL);
  assign disp_prod = rso_pkg::DISP_PROD_W'(s2_item.base) *
                     rso_pkg::DISP_PROD_W'(rso_pkg::DISP_MUL);

  always_comb begin
    s3_item_next             = s2_item;
    s3_item_next.disp_scaled = disp_prod[rso_pkg::DISP_SHIFT +: rso_pkg::DISP_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= item_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && item_valid) begin
      s1_item <= item;
    end
    if (s2_ready && s1_valid) begin
      s2_item.cmd             <= s1_item.cmd;
      s2_item.sig_byte_first  <= s1_item.sig_byte_first;
      s2_item.sig_byte_second <= s1_item.sig_byte_second;
      s2_item.gear_code       <= s1_item.gear_code;
      s2_item.base            <= base_prod[rso_pkg::BASE_SHIFT +: rso_pkg::SPEED_W];
      s2_item.disp_scaled     <= '0;
    end
    if (s3_ready && s2_valid) begin
      s3_item <= s3_item_next;
    end
  end

  assign calc_valid = s3_valid;
  assign calc       = s3_item;

endmodule

// ===== hdl/rso_state_update.sv =====
// Frame check, gear and speed state, and the averaging ring driven by ticks.
`timescale 1ns / 1ps

module rso_state_update (
  input  logic            clk,
  input  logic            rst,
  input  rso_pkg::cfg_t   cfg,
  input  logic            calc_valid,
  output logic            calc_ready,
  input  rso_pkg::calc_t  calc,
  output logic            st_valid,
  input  logic            st_ready,
  output rso_pkg::state_t st
);

  localparam logic [rso_pkg::RING_PTR_W-1:0] PTR_LAST =
    rso_pkg::RING_PTR_W'(rso_pkg::AVG_DEPTH - 1);

  logic [rso_pkg::GEAR_W-1:0]     gear_reg;
  logic                           last_valid;
  logic [rso_pkg::SPEED_W-1:0]    display_speed_reg;
  logic [rso_pkg::SPEED_W-1:0]    capped_speed_reg;
  logic [rso_pkg::SPEED_W-1:0]    speed_ring [rso_pkg::AVG_DEPTH];
  logic [rso_pkg::RING_PTR_W-1:0] ring_pointer;
  logic [rso_pkg::SUM_W-1:0]      ring_sum;

  logic [rso_pkg::GEAR_W-1:0]     gear_reg_next;
  logic                           last_valid_next;
  logic [rso_pkg::SPEED_W-1:0]    display_speed_reg_next;
  logic [rso_pkg::SPEED_W-1:0]    capped_speed_reg_next;
  logic [rso_pkg::RING_PTR_W-1:0] ring_pointer_next;
  logic [rso_pkg::SUM_W-1:0]      ring_sum_next;
  logic                           fire;
  logic                           step;
  logic [rso_pkg::SPEED_W-1:0]    cap_c;
  logic [rso_pkg::SPEED_W-1:0]    cap_d;

  assign calc_ready = !st_valid || st_ready;
  assign step       = calc_valid && calc_ready;

  always_comb begin
    gear_reg_next          = gear_reg;
    last_valid_next        = last_valid;
    display_speed_reg_next = display_speed_reg;
    capped_speed_reg_next  = capped_speed_reg;
    ring_pointer_next      = ring_pointer;
    ring_sum_next          = ring_sum;
    fire                   = 1'b0;
    cap_c                  = '0;
    cap_d                  = '0;
    case (calc.cmd)
      rso_pkg::CMD_FRAME: begin
        last_valid_next = (calc.sig_byte_first == cfg.sig_first) &&
                          (calc.sig_byte_second == cfg.sig_second);
        if (last_valid_next) begin
          gear_reg_next = rso_pkg::decode_gear(calc.gear_code, gear_reg);
          cap_c         = rso_pkg::capped_limit(gear_reg_next);
          cap_d         = rso_pkg::display_limit(gear_reg_next);
          if (gear_reg_next == rso_pkg::GEAR_NONE) begin
            capped_speed_reg_next  = calc.base;
            display_speed_reg_next = calc.base;
          end else begin
            capped_speed_reg_next  = (calc.base > cap_c) ? cap_c : calc.base;
            // cap lies far below the 13-bit scaled range, so clamp instead of wrap
            display_speed_reg_next = (calc.disp_scaled > rso_pkg::DISP_W'(cap_d)) ?
                                     cap_d : calc.disp_scaled[rso_pkg::SPEED_W-1:0];
          end
        end
      end
      rso_pkg::CMD_TICK: begin
        fire = last_valid && (display_speed_reg != '0);
        if (fire) begin
          ring_pointer_next = (ring_pointer == PTR_LAST) ? '0 : ring_pointer + 1'b1;
          // running sum: drop the overwritten entry, add the new one
          ring_sum_next = ring_sum - rso_pkg::SUM_W'(speed_ring[ring_pointer]) +
                          rso_pkg::SUM_W'(capped_speed_reg);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gear_reg          <= rso_pkg::GEAR_NONE;
      last_valid        <= 1'b0;
      display_speed_reg <= '0;
      capped_speed_reg  <= '0;
      ring_pointer      <= '0;
      ring_sum          <= '0;
      st_valid          <= 1'b0;
      for (int i = 0; i < rso_pkg::AVG_DEPTH; i++) begin
        speed_ring[i] <= '0;
      end
    end else begin
      if (calc_ready) begin
        st_valid <= calc_valid;
      end
      if (step) begin
        gear_reg          <= gear_reg_next;
        last_valid        <= last_valid_next;
        display_speed_reg <= display_speed_reg_next;
        capped_speed_reg  <= capped_speed_reg_next;
        ring_pointer      <= ring_pointer_next;
        ring_sum          <= ring_sum_next;
        if (fire) begin
          speed_ring[ring_pointer] <= capped_speed_reg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      st.status.frame_valid   <= last_valid_next;
      st.status.gear_number   <= gear_reg_next;
      st.status.display_speed <= display_speed_reg_next;
      st.status.capped_speed  <= capped_speed_reg_next;
      st.fire                 <= fire;
      st.ring_sum             <= ring_sum_next;
    end
  end

endmodule

// ===== hdl/rso_odometer.sv =====
// Distance increment stage, odometer count with remainder, and the result register.
`timescale 1ns / 1ps

module rso_odometer (
  input  logic               clk,
  input  logic               rst,
  input  logic               st_valid,
  output logic               st_ready,
  input  rso_pkg::state_t    st,
  output logic               result_valid,
  input  logic               result_ready,
  output rso_pkg::out_item_t result
);

  logic                         s5_valid;
  rso_pkg::status_t             s5_status;
  logic [rso_pkg::INC_W-1:0]    s5_inc;

  logic [rso_pkg::ODO_W-1:0]    odo_count;
  logic [rso_pkg::REM_W-1:0]    odo_rem;

  logic                         s5_ready;
  logic                         out_ready;
  logic [rso_pkg::INC_W-1:0]    inc;
  logic [rso_pkg::ACC_W-1:0]    acc_sum;
  logic [rso_pkg::ACC_W-1:0]    take;
  logic [rso_pkg::ACC_W-1:0]    rem_full;
  logic [rso_pkg::ODO_STEP_W-1:0] odo_step;
  logic [rso_pkg::ODO_W:0]      odo_sum;
  logic [rso_pkg::ODO_W-1:0]    odo_count_next;
  logic [rso_pkg::REM_W-1:0]    odo_rem_next;

  assign out_ready = !result_valid || result_ready;
  assign s5_ready  = !s5_valid || out_ready;
  assign st_ready  = s5_ready;

  assign inc = st.fire ? rso_pkg::INC_W'(st.ring_sum) * rso_pkg::INC_W'(rso_pkg::INC_FACTOR)
                       : '0;

  // Split remainder plus increment into whole tenths and a new remainder
  always_comb begin
    acc_sum  = rso_pkg::ACC_W'(odo_rem) + rso_pkg::ACC_W'(s5_inc);
    odo_step = '0;
    take     = '0;
    for (int j = 1; j <= rso_pkg::ODO_STEP_MAX; j++) begin
      if (acc_sum >= rso_pkg::ACC_W'(j * rso_pkg::ODO_UNIT)) begin
        odo_step = rso_pkg::ODO_STEP_W'(j);
        take     = rso_pkg::ACC_W'(j * rso_pkg::ODO_UNIT);
      end
    end
    rem_full       = acc_sum - take;
    odo_rem_next   = rem_full[rso_pkg::REM_W-1:0];
    odo_sum        = (rso_pkg::ODO_W + 1)'(odo_count) + (rso_pkg::ODO_W + 1)'(odo_step);
    odo_count_next = odo_sum[rso_pkg::ODO_W] ? rso_pkg::ODO_MAX
                                             : odo_sum[rso_pkg::ODO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid     <= 1'b0;
      result_valid <= 1'b0;
      odo_count    <= '0;
      odo_rem      <= '0;
    end else begin
      if (s5_ready) begin
        s5_valid <= st_valid;
      end
      if (out_ready) begin
        result_valid <= s5_valid;
      end
      if (out_ready && s5_valid) begin
        odo_count <= odo_count_next;
        odo_rem   <= odo_rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s5_ready && st_valid) begin
      s5_status <= st.status;
      s5_inc    <= inc;
    end
    if (out_ready && s5_valid) begin
      result.frame_valid   <= s5_status.frame_valid;
      result.gear_number   <= s5_status.gear_number;
      result.display_speed <= s5_status.display_speed;
      result.capped_speed  <= s5_status.capped_speed;
      result.odo_tenths    <= odo_count_next;
    end
  end

endmodule

// ===== hdl/rpm_speedometer_odometer_core.sv =====
// Throughput: one item per cycle; the six-stage pipeline (input register, rpm scale,
// display scale, state update, distance increment, result register) stalls only on result_ready.
// Each tick updates the odometer remainder in a feedback loop through odo_rem at the result stage.
// Reset (rst, synchronous, active high) clears gear, speeds, the five-entry ring, odometer
// and signature registers at once; items are accepted on the next cycle.
`timescale 1ns / 1ps

module rpm_speedometer_odometer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  rso_pkg::in_item_t          item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output rso_pkg::out_item_t         result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rso_pkg::ADDR_W-1:0] paddr,
  input  logic [rso_pkg::DATA_W-1:0] pwdata,
  output logic [rso_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  rso_pkg::cfg_t   cfg;
  logic            calc_valid;
  logic            calc_ready;
  rso_pkg::calc_t  calc;
  logic            st_valid;
  logic            st_ready;
  rso_pkg::state_t st;

  rso_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rso_speed_calc u_speed_calc (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .calc_valid (calc_valid),
    .calc_ready (calc_ready),
    .calc       (calc)
  );

  rso_state_update u_state_update (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .calc_valid (calc_valid),
    .calc_ready (calc_ready),
    .calc       (calc),
    .st_valid   (st_valid),
    .st_ready   (st_ready),
    .st         (st)
  );

  rso_odometer u_odometer (
    .clk          (clk),
    .rst          (rst),
    .st_valid     (st_valid),
    .st_ready     (st_ready),
    .st           (st),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== hdl/rso_checker.sv =====
// Port-level checks for the speedometer and odometer core, bound to the top level.
`timescale 1ns / 1ps

module rso_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_ready,
  input rso_pkg::out_item_t result
);

  logic [rso_pkg::ODO_W-1:0] last_odo;

  // hold the odometer of the last delivered beat
  always_ff @(posedge clk) begin
    if (rst) begin
      last_odo <= '0;
    end else if (result_valid && result_ready) begin
      last_odo <= result.odo_tenths;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  a_gear_caps: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.gear_number != rso_pkg::GEAR_NONE) |->
      (result.capped_speed <= rso_pkg::CAPPED_LIMIT_3) &&
      (result.display_speed <= rso_pkg::DISPLAY_LIMIT_3))
    else $error("speed above gear limit");

  a_no_gear_same: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.gear_number == rso_pkg::GEAR_NONE) |->
      result.display_speed == result.capped_speed)
    else $error("ungeared speeds differ");

  a_odo_monotonic: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.odo_tenths >= last_odo)
    else $error("odometer went backward");

endmodule

bind rpm_speedometer_odometer_core rso_checker u_rso_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== bench/rpm_speedometer_odometer_core_test.sv =====
// Self-checking bench for the speedometer and odometer core: directed and random frames and ticks.
`timescale 1ns / 1ps

module rpm_speedometer_odometer_core_test;

  localparam int              PHASE_ITEMS  = 350;
  localparam int              LONG_HOLD    = 200;
  localparam int              HOLD_AFTER   = 600;
  localparam int              STALL_LIMIT  = 3000;
  localparam int              DRAIN_CYCLES = 10;
  localparam int              REPORT_MAX   = 10;
  localparam int              RING_DEPTH   = 5;
  localparam longint unsigned RPM_NUM      = 6032;
  localparam longint unsigned RPM_DEN      = 100000;
  localparam longint unsigned SHOW_NUM     = 113;
  localparam longint unsigned SHOW_DEN     = 100;
  localparam longint unsigned DIST_FACTOR  = 11;
  localparam longint unsigned DIST_UNIT    = RING_DEPTH * 3600;
  localparam longint unsigned ACC_TOP      = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint unsigned ODO_TOP      = 64'h0000_0000_00FF_FFFF;

  class speedo_scoreboard;
    logic [rso_pkg::BYTE_W-1:0]  want_first;
    logic [rso_pkg::BYTE_W-1:0]  want_second;
    logic [rso_pkg::GEAR_W-1:0]  gear;
    logic                        frame_ok;
    logic [rso_pkg::SPEED_W-1:0] shown_speed;
    logic [rso_pkg::SPEED_W-1:0] limited_speed;
    logic [rso_pkg::SPEED_W-1:0] speed_ring [RING_DEPTH];
    int unsigned                 ring_slot;
    longint unsigned             distance;
    rso_pkg::out_item_t          expected_readings [$];
    int unsigned                 mismatches;
    int unsigned                 frames;
    int unsigned                 ticks;
    int unsigned                 counted_ticks;
    int unsigned                 readings;

    function new();
      want_first    = '0;
      want_second   = '0;
      gear          = rso_pkg::GEAR_NONE;
      frame_ok      = 1'b0;
      shown_speed   = '0;
      limited_speed = '0;
      foreach (speed_ring[i]) speed_ring[i] = '0;
      ring_slot     = 0;
      distance      = 0;
      mismatches    = 0;
      frames        = 0;
      ticks         = 0;
      counted_ticks = 0;
      readings      = 0;
    endfunction

    function void set_signature(input logic [rso_pkg::REG_IDX_W-1:0] idx,
                                input logic [rso_pkg::BYTE_W-1:0] value);
      case (idx)
        rso_pkg::REG_SIG_FIRST:  want_first = value;
        rso_pkg::REG_SIG_SECOND: want_second = value;
        default: ;
      endcase
    endfunction

    // Advance the dashboard state by one accepted beat and queue the reading it yields.
    function void note_item(input rso_pkg::in_item_t it);
      longint unsigned             base;
      longint unsigned             scaled;
      longint unsigned             ring_total;
      longint unsigned             odo;
      logic [rso_pkg::SPEED_W-1:0] cap_capped;
      logic [rso_pkg::SPEED_W-1:0] cap_shown;
      rso_pkg::out_item_t          r;
      if (it.cmd == rso_pkg::CMD_FRAME) begin
        frames++;
        frame_ok = (it.sig_byte_first == want_first) && (it.sig_byte_second == want_second);
        if (frame_ok) begin
          case (it.gear_code)
            rso_pkg::GEAR1_CODE_A, rso_pkg::GEAR1_CODE_B,
            rso_pkg::GEAR1_CODE_C: gear = rso_pkg::GEAR_1;
            rso_pkg::GEAR2_CODE_A, rso_pkg::GEAR2_CODE_B,
            rso_pkg::GEAR2_CODE_C: gear = rso_pkg::GEAR_2;
            rso_pkg::GEAR3_CODE_A, rso_pkg::GEAR3_CODE_B,
            rso_pkg::GEAR3_CODE_C: gear = rso_pkg::GEAR_3;
            default: ;
          endcase
          base = 64'(it.motor_rpm) * RPM_NUM / RPM_DEN;
          limited_speed = base[rso_pkg::SPEED_W-1:0];
          shown_speed   = base[rso_pkg::SPEED_W-1:0];
          if (gear != rso_pkg::GEAR_NONE) begin
            case (gear)
              rso_pkg::GEAR_1: begin
                cap_capped = rso_pkg::CAPPED_LIMIT_1;
                cap_shown  = rso_pkg::DISPLAY_LIMIT_1;
              end
              rso_pkg::GEAR_2: begin
                cap_capped = rso_pkg::CAPPED_LIMIT_2;
                cap_shown  = rso_pkg::DISPLAY_LIMIT_2;
              end
              default: begin
                cap_capped = rso_pkg::CAPPED_LIMIT_3;
                cap_shown  = rso_pkg::DISPLAY_LIMIT_3;
              end
            endcase
            // scaled value may pass 12 bits, but every display cap sits far below that
            scaled = base * SHOW_NUM / SHOW_DEN;
            if (base > cap_capped) limited_speed = cap_capped;
            shown_speed = (scaled > cap_shown) ? cap_shown : scaled[rso_pkg::SPEED_W-1:0];
          end
        end
      end else begin
        ticks++;
        if (frame_ok && shown_speed != '0) begin
          counted_ticks++;
          speed_ring[ring_slot] = limited_speed;
          ring_slot = (ring_slot + 1 == RING_DEPTH) ? 0 : ring_slot + 1;
          ring_total = 0;
          foreach (speed_ring[i]) ring_total += speed_ring[i];
          ring_total *= DIST_FACTOR;
          distance = (distance > ACC_TOP - ring_total) ? ACC_TOP : distance + ring_total;
        end
      end
      odo = distance / DIST_UNIT;
      if (odo > ODO_TOP) odo = ODO_TOP;
      r.frame_valid   = frame_ok;
      r.gear_number   = gear;
      r.display_speed = shown_speed;
      r.capped_speed  = limited_speed;
      r.odo_tenths    = odo[rso_pkg::ODO_W-1:0];
      expected_readings.push_back(r);
    endfunction

    function void check_reading(input rso_pkg::out_item_t got);
      rso_pkg::out_item_t want;
      readings++;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: result beat %h arrived with no reading pending", got);
        return;
      end
      want = expected_readings.pop_front();
      if (got.frame_valid !== want.frame_valid || got.gear_number !== want.gear_number ||
          got.display_speed !== want.display_speed ||
          got.capped_speed !== want.capped_speed || got.odo_tenths !== want.odo_tenths) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: reading %0d: expected valid=%0d gear=%0d disp=%0d cap=%0d odo=%0d,%s",
                   readings, want.frame_valid, want.gear_number, want.display_speed,
                   want.capped_speed, want.odo_tenths, "");
        if (mismatches <= REPORT_MAX)
          $display("       got      valid=%0d gear=%0d disp=%0d cap=%0d odo=%0d",
                   got.frame_valid, got.gear_number, got.display_speed,
                   got.capped_speed, got.odo_tenths);
      end
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         item_valid;
  logic                         item_ready;
  rso_pkg::in_item_t            item;
  logic                         result_valid;
  logic                         result_ready;
  rso_pkg::out_item_t           result;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rso_pkg::ADDR_W-1:0]   paddr;
  logic [rso_pkg::DATA_W-1:0]   pwdata;
  logic [rso_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic [rso_pkg::BYTE_W-1:0]   cfg_first;
  logic [rso_pkg::BYTE_W-1:0]   cfg_second;
  int unsigned                  settings_used;
  speedo_scoreboard             board = new();

  rpm_speedometer_odometer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rso_pkg::in_item_t frame_of(input logic [rso_pkg::BYTE_W-1:0] s1,
                                                 input logic [rso_pkg::BYTE_W-1:0] s2,
                                                 input logic [rso_pkg::RPM_W-1:0]  rpm,
                                                 input logic [rso_pkg::BYTE_W-1:0] code);
    rso_pkg::in_item_t it;
    it.cmd             = rso_pkg::CMD_FRAME;
    it.sig_byte_first  = s1;
    it.sig_byte_second = s2;
    it.motor_rpm       = rpm;
    it.gear_code       = code;
    return it;
  endfunction

  // Tick payload bytes are don't-care to the block; fill them with noise.
  function automatic rso_pkg::in_item_t tick_of();
    rso_pkg::in_item_t it;
    it = frame_of(8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
    it.cmd = rso_pkg::CMD_TICK;
    return it;
  endfunction

  function automatic rso_pkg::in_item_t random_item();
    rso_pkg::in_item_t          it;
    int unsigned                pick;
    logic [rso_pkg::BYTE_W-1:0] code;
    logic [rso_pkg::RPM_W-1:0]  rpm;
    pick = $urandom_range(0, 99);
    if (pick < 40) return tick_of();
    case ($urandom_range(0, 8))
      0:       code = rso_pkg::GEAR1_CODE_A;
      1:       code = rso_pkg::GEAR1_CODE_B;
      2:       code = rso_pkg::GEAR1_CODE_C;
      3:       code = rso_pkg::GEAR2_CODE_A;
      4:       code = rso_pkg::GEAR2_CODE_B;
      5:       code = rso_pkg::GEAR2_CODE_C;
      6:       code = rso_pkg::GEAR3_CODE_A;
      7:       code = rso_pkg::GEAR3_CODE_B;
      default: code = rso_pkg::GEAR3_CODE_C;
    endcase
    if ($urandom_range(0, 9) < 4) code = 8'($urandom);
    // favor rpm values that land around the gear caps
    case ($urandom_range(0, 9))
      0:             rpm = '0;
      1, 2, 3, 4:    rpm = 16'($urandom_range(0, 1300));
      default:       rpm = 16'($urandom);
    endcase
    it = frame_of(cfg_first, cfg_second, rpm, code);
    if (pick >= 88) begin
      case ($urandom_range(0, 2))
        0:       it.sig_byte_first  = cfg_first ^ 8'($urandom_range(1, 255));
        1:       it.sig_byte_second = cfg_second ^ 8'($urandom_range(1, 255));
        default: begin
          it.sig_byte_first  = 8'($urandom);
          it.sig_byte_second = 8'($urandom);
        end
      endcase
    end
    return it;
  endfunction

  // Offer one beat and hold it until accepted; valid stays high for the caller to drop.
  task automatic send_item(input rso_pkg::in_item_t it);
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    board.note_item(it);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned burst;
    int unsigned gap;
    burst = $urandom_range(1, 30);
    for (int unsigned k = 0; k < count; k++) begin
      send_item(random_item());
      burst--;
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          item_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
      end
    end
    item_valid <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leave the bus selected; back-to-back writes go straight into the next setup cycle.
  task automatic write_reg(input logic [rso_pkg::REG_IDX_W-1:0] idx,
                           input logic [rso_pkg::BYTE_W-1:0] value);
    logic [rso_pkg::DATA_W-1:0] word;
    word = $urandom;
    word[rso_pkg::BYTE_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_signature(idx, value);
  endtask

  task automatic set_signatures(input logic [rso_pkg::BYTE_W-1:0] first,
                                input logic [rso_pkg::BYTE_W-1:0] second);
    write_reg(rso_pkg::REG_SIG_FIRST, first);
    write_reg(rso_pkg::REG_SIG_SECOND, second);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_first  = first;
    cfg_second = second;
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) board.check_reading(result);
  end

  // Receiver: stall patterns that change every so often, plus one long hold-off.
  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned beat_no;
    bit          held_off;
    result_ready <= 1'b0;
    mode     = 0;
    left     = 0;
    beat_no  = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && board.readings >= HOLD_AFTER) begin
        held_off = 1'b1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        beat_no++;
        case (mode)
          0:       result_ready <= 1'b1;
          1:       result_ready <= 1'($urandom_range(0, 1));
          2:       result_ready <= (beat_no % 4 != 3);
          default: result_ready <= (beat_no % 5 == 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", quiet);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rso_pkg::in_item_t plan [$];
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    cfg_first     = '0;
    cfg_second    = '0;
    settings_used = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, signatures at their reset value.
    plan.push_back(tick_of());                                          // no frame seen yet
    plan.push_back(frame_of(cfg_first, cfg_second, 16'd0, 8'h00));     // unknown code, gear 0
    plan.push_back(tick_of());                                          // zero display speed
    plan.push_back(frame_of(cfg_first, cfg_second, 16'hFFFF, 8'hFF));  // top rpm, no cap
    plan.push_back(tick_of());
    plan.push_back(tick_of());
    plan.push_back(frame_of(cfg_first, cfg_second, 16'hFFFF, rso_pkg::GEAR1_CODE_A));
    plan.push_back(frame_of(cfg_first, cfg_second, 16'd500, rso_pkg::GEAR1_CODE_B));
    plan.push_back(frame_of(cfg_first, cfg_second, 16'd640, rso_pkg::GEAR1_CODE_C));
    plan.push_back(frame_of(cfg_first, cfg_second, 16'hFFFF, rso_pkg::GEAR2_CODE_A));
    plan.push_back(frame_of(cfg_first, cfg_second, 16'd900, rso_pkg::GEAR2_CODE_B));
    plan.push_back(frame_of(cfg_first, cfg_second, 16'd800, rso_pkg::GEAR2_CODE_C));
    // scaling past 12 bits
    plan.push_back(frame_of(cfg_first, cfg_second, 16'hFFFF, rso_pkg::GEAR3_CODE_A));
    plan.push_back(frame_of(cfg_first, cfg_second, 16'd1100, rso_pkg::GEAR3_CODE_B));
    plan.push_back(frame_of(cfg_first, cfg_second, 16'd1000, rso_pkg::GEAR3_CODE_C));
    plan.push_back(tick_of());
    // bad signature
    plan.push_back(frame_of(~cfg_first, ~cfg_second, 16'd1234, rso_pkg::GEAR1_CODE_A));
    plan.push_back(tick_of());                                          // last frame invalid
    plan.push_back(frame_of(cfg_first, cfg_second, 16'd300, 8'h80));   // keep gear 3
    repeat (5) plan.push_back(tick_of());                               // wrap the ring
    plan.push_back(frame_of(cfg_first, ~cfg_second, 16'd2000, rso_pkg::GEAR2_CODE_A));
    foreach (plan[i]) send_item(plan[i]);
    item_valid <= 1'b0;
    drain();

    set_signatures(8'hFF, 8'hFF);
    run_random(PHASE_ITEMS);
    drain();
    set_signatures(8'h00, 8'hFF);
    run_random(PHASE_ITEMS);
    drain();
    set_signatures(8'hFF, 8'h00);
    run_random(PHASE_ITEMS);
    drain();
    set_signatures(8'($urandom), 8'($urandom));
    run_random(PHASE_ITEMS);
    drain();
    set_signatures(8'h5A, 8'hA5);
    run_random(PHASE_ITEMS);
    drain();

    $display("Run covered %0d frames and %0d ticks (%0d advanced distance), %0d signature setups.",
             board.frames, board.ticks, board.counted_ticks, settings_used);
    $display("Odometer reached %0d tenths of a km; %0d mismatching readings.",
             board.distance / DIST_UNIT, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rso_pkg.sv
hdl/rso_cfg_regs.sv
hdl/rso_speed_calc.sv
hdl/rso_state_update.sv
hdl/rso_odometer.sv
hdl/rpm_speedometer_odometer_core.sv
hdl/rso_checker.sv
bench/rpm_speedometer_odometer_core_test.sv
